### src/assert_macros.svh
// Assertion macros shared by the formatter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define IFMT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define IFMT_NEVER(lbl, clk, rst_n, cond, msg) \
    `IFMT_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

### src/ifmt_pkg.sv
// Shared types, constants and helpers of the integer field formatter.
package ifmt_pkg;

    localparam int MAX_FIELD_DEF   = 63;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int DIGITS          = 10;
    localparam int LEN_W           = 4;

    typedef enum logic [1:0] {
        CMD_LIT  = 2'd0,
        CMD_DEC  = 2'd1,
        CMD_HEX  = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_MINUS    = 8'h2d;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_HEX_BASE = 8'h57;

    // One request as the back end emits it: spaces, sign, zeros, digits.
    typedef struct packed {
        logic [DIGITS-1:0][7:0] chars;
        logic [LEN_W-1:0]       len;
        logic                   neg;
        logic [5:0]             zeros;
        logic [5:0]             spaces;
    } t_job;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = CH_ZERO + {4'd0, d};
        end else begin
            c = CH_HEX_BASE + {4'd0, d};
        end
        return c;
    endfunction

endpackage

### src/integer_field_formatter.sv
// Literal and hex go from S_IDLE straight to S_FIN; decimal passes through S_CONV first.
// Front end takes a new request only when idle (decimal: 4 bits a cycle in S_CONV).
// Back end loads each request, then emits a character per cycle while output is free or popped.
// Queue decouples them; sustained rate is the slower of conversion and back-end emission.
// Reset (synchronous, active low) empties queue and result register and zeroes the running count.
module integer_field_formatter #(
    parameter int MAX_FIELD   = ifmt_pkg::MAX_FIELD_DEF,
    parameter int QUEUE_DEPTH = ifmt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         i_command,
    input  logic [7:0]         i_literal_byte,
    input  logic signed [31:0] i_value,
    input  logic [5:0]         i_field_width,
    input  logic               i_has_precision,
    input  logic [5:0]         i_precision,
    output logic               empty,
    input  logic               pop,
    output logic [7:0]         o_out_char,
    output logic               o_last,
    output logic [31:0]        o_chars_emitted
);

    logic           f_push;
    logic           q_full;
    ifmt_pkg::t_job f_job;
    logic           q_empty;
    logic           b_pop;
    ifmt_pkg::t_job q_job;

    ifmt_front #(
        .MAX_FIELD(MAX_FIELD)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_command      (i_command),
        .i_literal_byte (i_literal_byte),
        .i_value        (i_value),
        .i_field_width  (i_field_width),
        .i_has_precision(i_has_precision),
        .i_precision    (i_precision),
        .o_q_push       (f_push),
        .i_q_full       (q_full),
        .o_q_job        (f_job)
    );

    ifmt_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (f_push),
        .i_job  (f_job),
        .o_full (q_full),
        .i_pop  (b_pop),
        .o_job  (q_job),
        .o_empty(q_empty)
    );

    ifmt_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_q_job        (q_job),
        .o_q_pop        (b_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_out_char     (o_out_char),
        .o_last         (o_last),
        .o_chars_emitted(o_chars_emitted)
    );

endmodule

### src/ifmt_front.sv
// Front end: accepts requests, converts the value to digits, sizes the padding.
`include "assert_macros.svh"

module ifmt_front #(
    parameter int MAX_FIELD = ifmt_pkg::MAX_FIELD_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [1:0]        i_command,
    input  logic [7:0]        i_literal_byte,
    input  logic signed [31:0] i_value,
    input  logic [5:0]        i_field_width,
    input  logic              i_has_precision,
    input  logic [5:0]        i_precision,
    output logic              o_q_push,
    input  logic              i_q_full,
    output ifmt_pkg::t_job    o_q_job
);

    localparam int          BCD_W = 4 * ifmt_pkg::DIGITS;
    localparam logic [5:0]  W_MAX = 6'(MAX_FIELD);
    localparam logic [5:0]  P_MAX = 6'(MAX_FIELD - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_FIN
    } t_state;

    t_state                       r_state;
    logic                         r_lit;
    logic [7:0]                   r_lit_byte;
    logic                         r_neg;
    logic [31:0]                  r_mag;
    logic [BCD_W-1:0]             r_bcd;
    logic [5:0]                   r_width;
    logic [5:0]                   r_prec;
    logic                         r_has_prec;
    logic [2:0]                   r_step;

    logic [BCD_W-1:0]             n_bcd;
    logic [ifmt_pkg::LEN_W-1:0]   len_raw;
    logic [ifmt_pkg::LEN_W-1:0]   len;
    logic [5:0]                   zeros;
    logic [6:0]                   used;
    logic [5:0]                   spaces;
    logic                         drop;
    logic                         accept;
    ifmt_pkg::t_cmd               cmd;

    assign cmd    = ifmt_pkg::t_cmd'(i_command);
    assign o_full = (r_state != S_IDLE);
    assign accept = i_push && !o_full;

    // Shift-and-add-3, four magnitude bits per cycle.
    always_comb begin
        n_bcd = r_bcd;
        for (int k = 0; k < 4; k++) begin
            for (int d = 0; d < ifmt_pkg::DIGITS; d++) begin
                if (n_bcd[4*d +: 4] >= 4'd5) begin
                    n_bcd[4*d +: 4] = n_bcd[4*d +: 4] + 4'd3;
                end
            end
            n_bcd = {n_bcd[BCD_W-2:0], r_mag[31-k]};
        end
    end

    // Size the fields from the finished digits.
    always_comb begin
        len_raw = ifmt_pkg::LEN_W'(1);
        for (int d = 0; d < ifmt_pkg::DIGITS; d++) begin
            if (r_bcd[4*d +: 4] != 4'd0) begin
                len_raw = ifmt_pkg::LEN_W'(d + 1);
            end
        end
        len = (r_has_prec && r_prec == 6'd0 && r_bcd == '0) ? '0 : len_raw;
        zeros = (r_has_prec && r_prec > 6'(len)) ? (r_prec - 6'(len)) : 6'd0;
        used = 7'(len) + 7'(r_neg) + 7'(zeros);
        spaces = ({1'b0, r_width} > used) ? 6'({1'b0, r_width} - used) : 6'd0;
        drop = !r_lit && (used == 7'd0) && (r_width == 6'd0);
    end

    always_comb begin
        o_q_job = '0;
        if (r_lit) begin
            o_q_job.chars[0] = r_lit_byte;
            o_q_job.len      = ifmt_pkg::LEN_W'(1);
        end else begin
            for (int d = 0; d < ifmt_pkg::DIGITS; d++) begin
                o_q_job.chars[d] = ifmt_pkg::digit_char(r_bcd[4*d +: 4]);
            end
            o_q_job.len    = len;
            o_q_job.neg    = r_neg;
            o_q_job.zeros  = zeros;
            o_q_job.spaces = spaces;
        end
    end

    assign o_q_push = (r_state == S_FIN) && !i_q_full && !drop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lit   <= 1'b0;
            r_step  <= 3'd0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_lit      <= 1'b0;
                        r_lit_byte <= i_literal_byte;
                        r_neg      <= 1'b0;
                        r_step     <= 3'd0;
                        r_width    <= (i_field_width > W_MAX) ? W_MAX : i_field_width;
                        r_prec     <= (i_precision > P_MAX) ? P_MAX : i_precision;
                        r_has_prec <= i_has_precision;
                        unique case (cmd)
                            ifmt_pkg::CMD_LIT: begin
                                r_lit   <= 1'b1;
                                r_state <= S_FIN;
                            end
                            ifmt_pkg::CMD_DEC: begin
                                r_neg   <= i_value[31];
                                r_mag   <= i_value[31] ? (32'd0 - i_value) : i_value;
                                r_bcd   <= '0;
                                r_state <= S_CONV;
                            end
                            ifmt_pkg::CMD_HEX: begin
                                // hex nibbles are the value bits taken as unsigned
                                r_bcd   <= {{(BCD_W - 32){1'b0}}, i_value};
                                r_state <= S_FIN;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_CONV: begin
                    r_bcd  <= n_bcd;
                    r_mag  <= {r_mag[27:0], 4'd0};
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'd7) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (drop || !i_q_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `IFMT_ASSERT(a_len_range, i_clk, i_rst_n,
        o_q_push |-> (o_q_job.len <= ifmt_pkg::LEN_W'(ifmt_pkg::DIGITS)),
        "front: digit count out of range")
    `IFMT_ASSERT(a_total_cap, i_clk, i_rst_n,
        o_q_push |-> ((7'(o_q_job.spaces) + 7'(o_q_job.neg) + 7'(o_q_job.zeros)
            + 7'(o_q_job.len)) <= 7'd63),
        "front: request exceeds the character cap")

endmodule

### src/ifmt_queue.sv
// Short request queue between the front and back ends.
`include "assert_macros.svh"

module ifmt_queue #(
    parameter int DEPTH = ifmt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ifmt_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output ifmt_pkg::t_job o_job,
    output logic           o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ifmt_pkg::t_job   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `IFMT_NEVER(a_count_bound, i_clk, i_rst_n, r_count > CNT_W'(DEPTH),
        "queue: occupancy above depth")

endmodule

### src/ifmt_back.sv
// Back end: emits one character per cycle into the result register while that register is empty or being popped.
`include "assert_macros.svh"

module ifmt_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  ifmt_pkg::t_job i_q_job,
    output logic           o_q_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output logic [7:0]     o_out_char,
    output logic           o_last,
    output logic [31:0]    o_chars_emitted
);

    logic [ifmt_pkg::DIGITS-1:0][7:0] r_chars;
    logic [ifmt_pkg::LEN_W-1:0]       r_dg;
    logic                             r_neg;
    logic [5:0]                       r_zr;
    logic [5:0]                       r_sp;
    logic                             r_active;
    logic                             r_ovalid;
    logic [7:0]                       r_char;
    logic                             r_last;
    logic [31:0]                      r_cnt;

    logic [6:0]                       remaining;
    logic                             last;
    logic                             step;
    logic [7:0]                       ch;

    assign remaining = 7'(r_sp) + 7'(r_neg) + 7'(r_zr) + 7'(r_dg);
    assign last      = (remaining == 7'd1);
    assign step      = r_active && (!r_ovalid || i_pop);
    assign o_q_pop   = !r_active && !i_q_empty;

    always_comb begin
        priority if (r_sp != 6'd0) begin
            ch = ifmt_pkg::CH_SPACE;
        end else if (r_neg) begin
            ch = ifmt_pkg::CH_MINUS;
        end else if (r_zr != 6'd0) begin
            ch = ifmt_pkg::CH_ZERO;
        end else begin
            ch = r_chars[r_dg - 1'b1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (o_q_pop) begin
                r_chars  <= i_q_job.chars;
                r_dg     <= i_q_job.len;
                r_neg    <= i_q_job.neg;
                r_zr     <= i_q_job.zeros;
                r_sp     <= i_q_job.spaces;
                r_active <= 1'b1;
            end else if (step) begin
                priority if (r_sp != 6'd0) begin
                    r_sp <= r_sp - 6'd1;
                end else if (r_neg) begin
                    r_neg <= 1'b0;
                end else if (r_zr != 6'd0) begin
                    r_zr <= r_zr - 6'd1;
                end else begin
                    r_dg <= r_dg - 1'b1;
                end
                if (last) begin
                    r_active <= 1'b0;
                end
            end
            if (step) begin
                r_ovalid <= 1'b1;
                r_char   <= ch;
                r_last   <= last;
                r_cnt    <= r_cnt + 32'd1;
            end else if (i_pop) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_empty         = !r_ovalid;
    assign o_out_char      = r_char;
    assign o_last          = r_last;
    assign o_chars_emitted = r_cnt;

    `IFMT_NEVER(a_active_has_work, i_clk, i_rst_n, r_active && (remaining == 7'd0),
        "back: active request with nothing left to emit")
    `IFMT_ASSERT(a_count_step, i_clk, i_rst_n,
        step |=> (r_cnt == $past(r_cnt) + 32'd1),
        "back: running count did not advance by one")

endmodule
